FILE: hw/rtl/rdde_pkg.sv
package rdde_pkg;

  localparam int unsigned NumDigits = 5;
  localparam int unsigned DigIdxW   = 3;
  localparam int unsigned NumW      = 16;
  localparam int unsigned StepW     = 17;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [DigIdxW-1:0] LastDigIdx = DigIdxW'(NumDigits - 1);

  localparam logic [CfgIdxW-1:0] CfgGenMode     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTriggerCode = 1'b1;

  localparam logic [7:0]      TriggerReset = 8'h23;
  localparam logic [NumW-1:0] XsReset      = 16'd1;

  typedef enum logic [1:0] {
    ModeCount = 2'd0,
    ModeTimer = 2'd1,
    ModeAdc   = 2'd2,
    ModeXor   = 2'd3
  } mode_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // j times the decimal weight of digit position k, most significant first
  function automatic logic [StepW-1:0] digit_step(logic [DigIdxW-1:0] k, int unsigned j);
    logic [StepW-1:0] r;
    case (k)
      3'd0:    r = StepW'(10000 * j);
      3'd1:    r = StepW'(1000 * j);
      3'd2:    r = StepW'(100 * j);
      3'd3:    r = StepW'(10 * j);
      default: r = StepW'(j);
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/random_decimal_digit_emitter.sv
// Takes one received byte per cycle with its entropy sample while the queue
// has room. A byte equal to the trigger code forms a 16-bit number (count,
// timer, ADC x64 or xorshift16, by mode) and queues it; the digit unit then
// gives it out as five decimal digits, most significant first, one per cycle
// while out_ready_i takes them, last_digit_o marking the fifth. Other bytes
// only advance the event counter and give nothing. The digit unit works one
// decimal place at a time; the two-entry queue lets up to two further
// triggers be taken meanwhile, and any byte is taken whenever the queue has
// room. The first digit is registered in dig_q as the item is popped.
module random_decimal_digit_emitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic [15:0]                   entropy_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    digit_o,
  output logic                          last_digit_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdde_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdde_pkg::CfgDataW-1:0] cfg_data_i
);
  import rdde_pkg::*;

  q_stat_t         q_stat;
  logic            push, pop;
  logic [NumW-1:0] push_data, head;

  rdde_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .entropy_sample_i (entropy_sample_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  rdde_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  rdde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_o      (digit_o),
    .last_digit_o (last_digit_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> digit_o <= 4'd9)
    else $error("digit out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_stat.full))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && q_stat.empty))
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_digit_o && q_stat.empty && !push) |=> !out_valid_o)
    else $error("digit given without a queued number");

endmodule

FILE: hw/rtl/rdde_fifo.sv
module rdde_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [rdde_pkg::NumW-1:0] push_data_i,
  input  logic                      pop_i,
  output logic [rdde_pkg::NumW-1:0] head_o,
  output rdde_pkg::q_stat_t         stat_o
);
  import rdde_pkg::*;

  logic [NumW-1:0]  mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/rdde_front.sv
module rdde_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic [15:0]                   entropy_sample_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdde_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdde_pkg::CfgDataW-1:0] cfg_data_i,
  input  rdde_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output logic [rdde_pkg::NumW-1:0]     push_data_o
);
  import rdde_pkg::*;

  mode_e           mode_q, mode_d;
  logic [7:0]      trig_q, trig_d;
  logic [NumW-1:0] xs_q, xs_d;
  logic [NumW-1:0] ctr_q, ctr_d;

  logic            accept, is_trig;
  logic [NumW-1:0] xs1, xs2, xs3, number;
  logic [5:0]      nib_sum;
  logic [4:0]      fold;
  logic [2:0]      mod5;
  logic [3:0]      last_dig;

  assign in_ready_o  = !q_stat_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign is_trig     = (rx_byte_i == trig_q);

  assign xs1 = xs_q ^ (xs_q << 7);
  assign xs2 = xs1 ^ (xs1 >> 9);
  assign xs3 = xs2 ^ (xs2 << 8);

  always_comb begin
    case (mode_q)
      ModeCount: number = ctr_q + 1'b1;
      ModeTimer: number = entropy_sample_i;
      ModeAdc:   number = {entropy_sample_i[9:0], 6'd0};
      default:   number = xs3;
    endcase
  end

  // least significant decimal digit: residue mod 5 from nibble sum, parity from bit 0
  always_comb begin
    nib_sum = 6'(number[3:0]) + 6'(number[7:4]) + 6'(number[11:8]) + 6'(number[15:12]);
    fold    = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);
    if (fold >= 5'd15) begin
      mod5 = 3'(fold - 5'd15);
    end else if (fold >= 5'd10) begin
      mod5 = 3'(fold - 5'd10);
    end else if (fold >= 5'd5) begin
      mod5 = 3'(fold - 5'd5);
    end else begin
      mod5 = 3'(fold);
    end
    if (mod5[0] == number[0]) begin
      last_dig = {1'b0, mod5};
    end else begin
      last_dig = {1'b0, mod5} + 4'd5;
    end
  end

  assign push_o      = accept && is_trig;
  assign push_data_o = number;

  always_comb begin
    mode_d = mode_q;
    trig_d = trig_q;
    xs_d   = xs_q;
    ctr_d  = ctr_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgGenMode:     mode_d = mode_e'(cfg_data_i[1:0]);
        CfgTriggerCode: trig_d = cfg_data_i;
        default:        ;
      endcase
    end
    if (accept) begin
      if (is_trig) begin
        ctr_d = NumW'(last_dig) + 1'b1;
        if (mode_q == ModeXor) begin
          xs_d = xs3;
        end
      end else begin
        ctr_d = ctr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeXor;
      trig_q <= TriggerReset;
      xs_q   <= XsReset;
      ctr_q  <= '0;
    end else begin
      mode_q <= mode_d;
      trig_q <= trig_d;
      xs_q   <= xs_d;
      ctr_q  <= ctr_d;
    end
  end

endmodule

FILE: hw/rtl/rdde_back.sv
module rdde_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rdde_pkg::q_stat_t         q_stat_i,
  input  logic [rdde_pkg::NumW-1:0] head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                digit_o,
  output logic                      last_digit_o
);
  import rdde_pkg::*;

  logic               busy_q, busy_d;
  logic [DigIdxW-1:0] idx_q, idx_d;
  logic [NumW-1:0]    rest_q, rest_d;
  logic               oval_q, oval_d;
  logic [3:0]         dig_q, dig_d;
  logic               last_q, last_d;

  logic               advance;
  logic [DigIdxW-1:0] idx;
  logic [NumW-1:0]    src;
  logic [StepW-1:0]   sub;
  logic [3:0]         dig;

  assign idx     = busy_q ? idx_q : '0;
  assign src     = busy_q ? rest_q : head_i;
  assign advance = (busy_q || !q_stat_i.empty) && (!oval_q || out_ready_i);
  assign pop_o   = advance && !busy_q;

  always_comb begin
    sub = '0;
    dig = '0;
    for (int unsigned j = 1; j < 10; j++) begin
      if (StepW'(src) >= digit_step(idx, j)) begin
        sub = digit_step(idx, j);
        dig = 4'(j);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rest_d = rest_q;
    oval_d = oval_q;
    dig_d  = dig_q;
    last_d = last_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (advance) begin
      oval_d = 1'b1;
      dig_d  = dig;
      last_d = (idx == LastDigIdx);
      rest_d = NumW'(StepW'(src) - sub);
      idx_d  = idx + 1'b1;
      busy_d = (idx != LastDigIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    dig_q  <= dig_d;
    last_q <= last_d;
  end

  assign out_valid_o  = oval_q;
  assign digit_o      = dig_q;
  assign last_digit_o = last_q;

endmodule
